@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: lbl");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m: lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ sv/cpvpi_pkg.sv @@
package cpvpi_pkg;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    RegPosGain   = 3'd0,
    RegVelLimit  = 3'd1,
    RegVelPGain  = 3'd2,
    RegVelIGain  = 3'd3,
    RegTickPer   = 3'd4,
    RegIntLimit  = 3'd5,
    RegGravity   = 3'd6,
    RegLatLimit  = 3'd7
  } reg_idx_e;

  // Shared unit operations
  typedef enum logic [1:0] {
    OpNone = 2'd0,
    OpSqrt = 2'd1,
    OpDiv  = 2'd2
  } op_e;

  typedef struct packed {
    logic  start;
    op_e   op;
  } seq_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clampsym(input logic signed [31:0] v,
                                                  input logic [30:0] lim);
    logic signed [32:0] l;
    logic signed [31:0] r;
    l = $signed({2'b00, lim});
    if (33'(v) > l) r = 32'(l);
    else if (33'(v) < -l) r = 32'(-l);
    else r = v;
    return r;
  endfunction
endpackage

@@ sv/cascaded_position_velocity_pi_thrust_dir_unit.sv @@
// Result timing is set by the shared divide/square-root unit: two roots and three divides,
// plus two extra divides when the lateral bound scales x and y; the direction divides are
// skipped when the norm comes out zero.
// Throughput: one word at a time; in_stall_o stays high until the result is taken, so a
// new word is taken only once the previous result has been taken.
// Reset: asynchronous active low; configuration registers take reset values, integrators clear.
module cascaded_position_velocity_pi_thrust_dir_unit #(
  parameter int unsigned FRAC_BITS = cpvpi_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpvpi_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          target_x_i,
  input  logic signed [31:0]          target_y_i,
  input  logic signed [31:0]          target_z_i,
  input  logic signed [31:0]          pos_x_i,
  input  logic signed [31:0]          pos_y_i,
  input  logic signed [31:0]          pos_z_i,
  input  logic signed [31:0]          vel_x_i,
  input  logic signed [31:0]          vel_y_i,
  input  logic signed [31:0]          vel_z_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [17:0]          dir_x_o,
  output logic signed [17:0]          dir_y_o,
  output logic signed [17:0]          dir_z_o,
  output logic signed [31:0]          vref_x_o,
  output logic signed [31:0]          vref_y_o,
  output logic signed [31:0]          vref_z_o
);
  import cpvpi_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    StIdle, StPerr, StVref, StVerr, StInteg, StAcc, StGrav,
    StLatSq, StLatSqrt, StLatDiv, StNormSq, StNormSqrt, StDirDiv, StOut
  } state_e;

  // ---- configuration registers
  logic [30:0] regs_q [NumRegs];
  logic [2:0]  cfg_idx;
  logic        cfg_wr;
  assign cfg_idx = paddr[AddrW-1:2];
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {1'b0, regs_q[cfg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[RegPosGain]  <= 31'd65536;
      regs_q[RegVelLimit] <= 31'd327680;
      regs_q[RegVelPGain] <= 31'd65536;
      regs_q[RegVelIGain] <= 31'd6554;
      regs_q[RegTickPer]  <= 31'd655;
      regs_q[RegIntLimit] <= 31'd65536;
      regs_q[RegGravity]  <= 31'd642908;
      regs_q[RegLatLimit] <= 31'd450165;
    end else if (cfg_wr) begin
      if (cfg_idx == RegTickPer) regs_q[cfg_idx] <= {14'd0, pwdata[16:0]};
      else regs_q[cfg_idx] <= pwdata[30:0];
    end
  end

  // ---- shared multiplier (32x32 signed, registered product)
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_q;
  always_ff @(posedge clk_i) prod_q <= ma * mb;
  logic signed [63:0] prod_sh;
  assign prod_sh = prod_q >>> FRAC_BITS;   // arithmetic shift floors

  // ---- divide / square-root unit
  seq_cmd_t    du_cmd;
  seq_sts_t    du_sts;
  logic [63:0] du_a, du_b, du_res;
  cpvpi_divsqrt u_du (
    .clk_i, .rst_ni, .cmd_i(du_cmd), .a_i(du_a), .b_i(du_b),
    .sts_o(du_sts), .res_o(du_res)
  );

  // ---- sequencer
  state_e state_q;
  logic [1:0] ax_q;           // axis counter
  logic       ph_q;           // phase within a step (issue / collect)
  logic signed [31:0] tgt_q [3], pos_q [3], vel_q [3];
  logic signed [31:0] perr_q [3], vref_q [3], verr_q [3], integ_q [3], acc_q [3];
  logic signed [17:0] dir_q [3];
  logic signed [31:0] tmp_q;
  logic [63:0] sum_q;
  logic [63:0] norm_q;
  logic        neg_q;
  logic        out_valid_q;

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign dir_x_o = dir_q[0];
  assign dir_y_o = dir_q[1];
  assign dir_z_o = dir_q[2];
  assign vref_x_o = vref_q[0];
  assign vref_y_o = vref_q[1];
  assign vref_z_o = vref_q[2];

  logic signed [31:0] cur_a;
  logic [63:0] a_abs;
  assign cur_a = acc_q[ax_q];
  assign a_abs = cur_a[31] ? 64'(-65'(cur_a)) : 64'(cur_a);

  always_comb begin
    ma = '0; mb = '0;
    du_cmd = '{start: 1'b0, op: OpNone};
    du_a = '0; du_b = '0;
    case (state_q)
      StVref:  begin ma = $signed({1'b0, regs_q[RegPosGain]}); mb = perr_q[ax_q]; end
      StInteg: begin ma = verr_q[ax_q]; mb = $signed({1'b0, regs_q[RegTickPer]}); end
      StAcc: begin
        if (!ph_q) begin ma = $signed({1'b0, regs_q[RegVelPGain]}); mb = verr_q[ax_q]; end
        else begin ma = $signed({1'b0, regs_q[RegVelIGain]}); mb = integ_q[ax_q]; end
      end
      StLatSq, StNormSq: begin ma = cur_a; mb = cur_a; end
      StLatSqrt, StNormSqrt: begin
        du_cmd = '{start: !ph_q, op: OpSqrt}; du_a = sum_q;
      end
      StLatDiv: begin
        // a * lateral_limit is registered by the shared multiplier before the divide starts
        ma = cur_a; mb = $signed({1'b0, regs_q[RegLatLimit]});
        du_cmd = '{start: !ph_q && neg_q, op: OpDiv};
        du_a = prod_q[63] ? -prod_q : prod_q; du_b = norm_q;
      end
      StDirDiv: begin
        du_cmd = '{start: !ph_q && (norm_q != 64'd0), op: OpDiv};
        du_a = a_abs << 16; du_b = norm_q;
      end
      default: ;
    endcase
  end

  // raw product, used for squares (full, unshifted)
  logic [63:0] sq;
  assign sq = 64'(prod_q);

  // multiplier is issued in one phase and read in the next: ph_q toggles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ax_q <= '0; ph_q <= 1'b0; out_valid_q <= 1'b0;
      tmp_q <= '0; neg_q <= 1'b0;
      for (int i = 0; i < 3; i++) integ_q[i] <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            tgt_q[0] <= target_x_i; tgt_q[1] <= target_y_i; tgt_q[2] <= target_z_i;
            pos_q[0] <= pos_x_i; pos_q[1] <= pos_y_i; pos_q[2] <= pos_z_i;
            vel_q[0] <= vel_x_i; vel_q[1] <= vel_y_i; vel_q[2] <= vel_z_i;
            state_q <= StPerr; ax_q <= '0; ph_q <= 1'b0;
          end
        end
        StPerr: begin
          perr_q[ax_q] <= sat32(66'(tgt_q[ax_q]) - 66'(pos_q[ax_q]));
          ax_q <= 2'((ax_q == 2'd2) ? 0 : ax_q + 2'd1);
          if (ax_q == 2'd2) state_q <= StVref;
        end
        StVref: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            vref_q[ax_q] <= clampsym(sat32(66'(prod_sh)), regs_q[RegVelLimit]);
            state_q <= StVerr;
          end
        end
        StVerr: begin
          verr_q[ax_q] <= sat32(66'(vref_q[ax_q]) - 66'(vel_q[ax_q]));
          state_q <= StInteg;
        end
        StInteg: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            integ_q[ax_q] <= clampsym(sat32(66'(integ_q[ax_q]) + 66'(sat32(66'(prod_sh)))),
                                      regs_q[RegIntLimit]);
            state_q <= StAcc;
          end
        end
        StAcc: begin
          // phases: issue P (0), take P / issue I (1), take I (2 via tmp)
          if (!ph_q && tmp_q == 32'sd0 && !neg_q) begin
            ph_q <= 1'b1;
          end else if (ph_q) begin
            tmp_q <= sat32(66'(prod_sh));
            neg_q <= 1'b1;
            ph_q <= 1'b0;
          end else begin
            acc_q[ax_q] <= sat32(66'(tmp_q) + 66'(sat32(66'(prod_sh))));
            tmp_q <= '0; neg_q <= 1'b0;
            if (ax_q == 2'd2) begin
              state_q <= StGrav; ax_q <= '0;
            end else begin
              ax_q <= ax_q + 2'd1; state_q <= StVref;
            end
          end
        end
        StGrav: begin
          acc_q[2] <= sat32(66'(acc_q[2]) - 66'(regs_q[RegGravity]));
          sum_q <= '0; state_q <= StLatSq; ax_q <= '0;
        end
        StLatSq, StNormSq: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            sum_q <= sum_q + sq;
            if (ax_q == ((state_q == StLatSq) ? 2'd1 : 2'd2)) begin
              ax_q <= '0;
              state_q <= (state_q == StLatSq) ? StLatSqrt : StNormSqrt;
            end else begin
              ax_q <= ax_q + 2'd1;
            end
          end
        end
        StLatSqrt, StNormSqrt: begin
          ph_q <= 1'b1;
          if (du_sts.done) begin
            ph_q <= 1'b0;
            norm_q <= du_res;
            if (state_q == StLatSqrt) begin
              if (du_res > 64'(regs_q[RegLatLimit])) state_q <= StLatDiv;
              else begin state_q <= StNormSq; sum_q <= '0; end
            end else begin
              state_q <= StDirDiv;
            end
          end
        end
        StLatDiv, StDirDiv: begin
          ph_q <= 1'b1;
          if (state_q == StDirDiv && norm_q == 64'd0) begin
            dir_q[0] <= '0; dir_q[1] <= '0; dir_q[2] <= '0;
            ph_q <= 1'b0; state_q <= StOut; out_valid_q <= 1'b1;
          end else if (state_q == StLatDiv && !ph_q && !neg_q) begin
            // product forming; divide starts next cycle
            ph_q <= 1'b0; neg_q <= 1'b1;
          end else if (du_sts.done) begin
            ph_q <= 1'b0;
            if (state_q == StLatDiv) begin
              neg_q <= 1'b0;
              acc_q[ax_q] <= cur_a[31] ? 32'(-65'(du_res)) : du_res[31:0];
              if (ax_q == 2'd1) begin
                ax_q <= '0; state_q <= StNormSq; sum_q <= '0;
              end else ax_q <= ax_q + 2'd1;
            end else begin
              dir_q[ax_q] <= (du_res > 64'd65536)
                ? (cur_a[31] ? -18'sd65536 : 18'sd65536)
                : (cur_a[31] ? 18'(-19'(du_res[17:0])) : du_res[17:0]);
              if (ax_q == 2'd2) begin
                ax_q <= '0; state_q <= StOut; out_valid_q <= 1'b1;
              end else ax_q <= ax_q + 2'd1;
            end
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0; state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_only_in_out, clk_i, rst_ni, out_valid_q |-> state_q == StOut)
  `ASSERT_IMPL(a_stable_out, clk_i, rst_ni,
    out_valid_q && out_stall_i |=> out_valid_q && $stable(vref_q[0]))
  `ASSERT_NEVER(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && out_valid_q)
endmodule

@@ sv/cpvpi_divsqrt.sv @@
// Bit-serial restoring unit: 64-bit integer square root (two radicand bits a cycle)
// or 64/64 unsigned divide (one quotient bit a cycle).
module cpvpi_divsqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cpvpi_pkg::seq_cmd_t  cmd_i,
  input  logic [63:0]          a_i,
  input  logic [63:0]          b_i,
  output cpvpi_pkg::seq_sts_t  sts_o,
  output logic [63:0]          res_o
);
  import cpvpi_pkg::*;
  `include "assert_macros.svh"

  logic [63:0] x_q, x_d, r_q, r_d, b_q, b_d, d_q, d_d;
  logic [6:0]  cnt_q, cnt_d;
  op_e         op_q, op_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] rem_sh;
  logic [63:0] trial;

  always_comb begin
    x_d = x_q; r_d = r_q; b_d = b_q; d_d = d_q; cnt_d = cnt_q; op_d = op_q;
    busy_d = busy_q; done_d = 1'b0;
    rem_sh = '0; trial = '0;
    if (cmd_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d = cmd_i.op;
      x_d = a_i;
      r_d = '0;
      d_d = b_i;
      b_d = 64'h4000_0000_0000_0000;
      cnt_d = (cmd_i.op == OpSqrt) ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      if (op_q == OpSqrt) begin
        trial = r_q + b_q;
        if (x_q >= trial) begin
          x_d = x_q - trial;
          r_d = (r_q >> 1) + b_q;
        end else begin
          r_d = r_q >> 1;
        end
        b_d = b_q >> 2;
      end else begin
        // r: remainder, x: dividend shifting into quotient
        rem_sh = {r_q, x_q[63]};
        x_d = {x_q[62:0], 1'b0};
        if (rem_sh >= {1'b0, d_q}) begin
          r_d = 64'(rem_sh - {1'b0, d_q});
          x_d[0] = 1'b1;
        end else begin
          r_d = rem_sh[63:0];
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; op_q <= OpNone;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; r_q <= r_d; b_q <= b_d; d_q <= d_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o = (op_q == OpSqrt) ? r_q : x_q;

  `ASSERT_NEVER(a_done_busy, clk_i, rst_ni, done_q && busy_q)
  `ASSERT_IMPL(a_cnt_idle, clk_i, rst_ni, !busy_q |-> cnt_q == 7'd0)
  `ASSERT_IMPL(a_done_after, clk_i, rst_ni, done_q |-> $past(busy_q))
endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpvpi_pkg::*;

  typedef struct {
    logic signed [31:0] tgt [3];
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
  } tick_t;

  typedef struct {
    logic signed [17:0] dir  [3];
    logic signed [31:0] vref [3];
  } thrust_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint DIR_ONE = 65536;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] tgt_d [3] = '{default: '0};
  logic signed [31:0] pos_d [3] = '{default: '0};
  logic signed [31:0] vel_d [3] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] dir_o [3];
  logic signed [31:0] vref_o [3];

  tick_t   tick_q [$];
  thrust_t thrust_q [$];
  longint  gains [NumRegs];
  longint  integ [3];
  int      send_idle = 0, recv_stall = 0;
  int      hold_cycles = 0;
  int      fails = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cascaded_position_velocity_pi_thrust_dir_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .target_x_i(tgt_d[0]), .target_y_i(tgt_d[1]), .target_z_i(tgt_d[2]),
    .pos_x_i(pos_d[0]), .pos_y_i(pos_d[1]), .pos_z_i(pos_d[2]),
    .vel_x_i(vel_d[0]), .vel_y_i(vel_d[1]), .vel_z_i(vel_d[2]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .dir_x_o(dir_o[0]), .dir_y_o(dir_o[1]), .dir_z_o(dir_o[2]),
    .vref_x_o(vref_o[0]), .vref_y_o(vref_o[1]), .vref_z_o(vref_o[2])
  );

  function automatic longint sat_word(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // exact product, floor shift by the fraction bits, saturate
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat_word(p >>> FracBitsDef);
  endfunction

  function automatic longint root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // one control tick: advances the integrators and returns the thrust word
  function automatic thrust_t predict_thrust(tick_t t);
    thrust_t res;
    longint acc [3];
    longint perr, verr, vr, lat, n;
    longint unsigned s;
    for (int i = 0; i < 3; i++) begin
      perr = sat_word(longint'(t.tgt[i]) - longint'(t.pos[i]));
      vr = clamp_sym(qmul(gains[RegPosGain], perr), gains[RegVelLimit]);
      verr = sat_word(vr - longint'(t.vel[i]));
      integ[i] = clamp_sym(sat_word(integ[i] + qmul(verr, gains[RegTickPer])),
                           gains[RegIntLimit]);
      acc[i] = sat_word(qmul(gains[RegVelPGain], verr) + qmul(gains[RegVelIGain], integ[i]));
      res.vref[i] = vr[31:0];
    end
    acc[2] = sat_word(acc[2] - gains[RegGravity]);
    s = longint'(acc[0] * acc[0]) + longint'(acc[1] * acc[1]);
    lat = root_floor(s);
    if (lat > gains[RegLatLimit]) begin
      acc[0] = (acc[0] * gains[RegLatLimit]) / lat;
      acc[1] = (acc[1] * gains[RegLatLimit]) / lat;
    end
    s = longint'(acc[0] * acc[0]) + longint'(acc[1] * acc[1]) + longint'(acc[2] * acc[2]);
    n = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      vr = (n != 0) ? clamp_sym((acc[i] * DIR_ONE) / n, DIR_ONE) : 0;
      res.dir[i] = vr[17:0];
    end
    return res;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    tick_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        for (int i = 0; i < 3; i++) begin
          t.tgt[i] = tgt_d[i];
          t.pos[i] = pos_d[i];
          t.vel[i] = vel_d[i];
        end
        thrust_q.push_back(predict_thrust(t));
      end
      if (!in_valid || !in_stall) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          t = tick_q.pop_front();
          tgt_d <= t.tgt;
          pos_d <= t.pos;
          vel_d <= t.vel;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    thrust_t e;
    string ax;
    if (rst_n && out_valid && !out_stall) begin
      if (thrust_q.size() == 0) begin
        $error("unexpected word");
        fails++;
      end else begin
        e = thrust_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          ax = (i == 0) ? "x" : (i == 1) ? "y" : "z";
          if (dir_o[i] !== e.dir[i]) begin
            $error("dir_%s expected %0d got %0d", ax, e.dir[i], dir_o[i]);
            fails++;
          end
          if (vref_o[i] !== e.vref[i]) begin
            $error("vref_%s expected %0d got %0d", ax, e.vref[i], vref_o[i]);
            fails++;
          end
        end
      end
    end
    out_stall <= (hold_cycles > 0) || ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  task automatic reg_write(reg_idx_e idx, longint v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * int'(idx));
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gains[idx] = v;
  endtask

  // checked mid-cycle so the driver's updates at the edge have settled
  task automatic wait_idle();
    while (tick_q.size() > 0 || in_valid || thrust_q.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_val(bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(524287)) - 262144;
  endfunction

  task automatic push_tick(logic signed [31:0] tg, logic signed [31:0] ps,
                           logic signed [31:0] vl);
    tick_t t;
    for (int i = 0; i < 3; i++) begin
      t.tgt[i] = tg;
      t.pos[i] = ps;
      t.vel[i] = vl;
    end
    tick_q.push_back(t);
  endtask

  task automatic push_random(int n);
    tick_t t;
    bit wide;
    for (int k = 0; k < n; k++) begin
      wide = ($urandom_range(99) < 25);
      for (int i = 0; i < 3; i++) begin
        t.pos[i] = rand_val(wide);
        // mostly hover near the target so the loops stay out of saturation
        t.tgt[i] = wide ? rand_val(1) : t.pos[i] + ($signed($urandom_range(131071)) - 65536);
        t.vel[i] = wide ? rand_val(1) : $signed($urandom_range(131071)) - 65536;
      end
      tick_q.push_back(t);
    end
  endtask

  function automatic longint pick_gain(longint lo, longint hi, longint typ);
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      2: return $urandom_range(int'(hi > 2 * typ ? 2 * typ : hi), int'(lo));
      default: return typ;
    endcase
  endfunction

  task automatic random_config();
    reg_write(RegPosGain,  pick_gain(0, QMAX, 65536));
    reg_write(RegVelLimit, pick_gain(0, QMAX, 327680));
    reg_write(RegVelPGain, pick_gain(0, QMAX, 65536));
    reg_write(RegVelIGain, pick_gain(0, QMAX, 6554));
    reg_write(RegTickPer,  pick_gain(1, 65536, 655));
    reg_write(RegIntLimit, pick_gain(0, QMAX, 65536));
    reg_write(RegGravity,  pick_gain(0, QMAX, 642908));
    reg_write(RegLatLimit, pick_gain(1, QMAX, 450165));
  endtask

  initial begin
    gains = '{65536, 327680, 65536, 6554, 655, 65536, 642908, 450165};
    integ = '{0, 0, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: reset settings, zero and saturating errors
    push_tick(0, 0, 0);
    push_tick(32'sh7fffffff, 32'sh80000000, 0);
    push_tick(32'sh80000000, 32'sh7fffffff, 0);
    push_tick(0, 0, 32'sh7fffffff);
    push_tick(0, 0, 32'sh80000000);
    push_tick(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_tick(32'sh80000000, 32'sh80000000, 32'sh80000000);
    wait_idle();
    // integrator driven into its clamp, wide references
    reg_write(RegTickPer, 65536);
    reg_write(RegVelLimit, QMAX);
    reg_write(RegPosGain, QMAX);
    push_tick(1 << 20, 0, 0);
    push_tick(-(1 << 20), 0, 0);
    push_tick(32'sh80000000, 0, 32'sh7fffffff);
    wait_idle();
    // zero acceleration gives a zero direction
    reg_write(RegVelPGain, 0);
    reg_write(RegVelIGain, 0);
    reg_write(RegGravity, 0);
    push_tick(12345, -999, 777);
    push_tick(0, 0, 0);
    wait_idle();
    // tiny lateral bound squashes x/y
    reg_write(RegVelPGain, QMAX);
    reg_write(RegLatLimit, 1);
    reg_write(RegIntLimit, QMAX);
    reg_write(RegGravity, QMAX);
    push_tick(1 << 18, 0, 0);
    push_tick(-(1 << 18), 3, -5);
    push_tick(0, 0, 0);
    wait_idle();

    // random phases under varied idling
    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 65; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 65; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      if (ph == 4) hold_cycles = 3000;
      push_random(170);
      wait_idle();
    end

    repeat (400) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/cpvpi_pkg.sv
sv/cpvpi_divsqrt.sv
sv/cascaded_position_velocity_pi_thrust_dir_unit.sv
tb/tb.sv
